>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the DCC packet builder RTL.
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(name, prop)
`define ASSERT_ALWAYS(name, prop)

`endif

`endif

>>> rtl/dcc_opb_pkg.sv
// ----------------------------------------------------------------------------
// dcc_opb_pkg
// Types, constants and the packet assembly function of the DCC packet builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_opb_pkg;

  localparam int unsigned PreambleW     = 6;
  localparam int unsigned AddrW         = 16;
  localparam int unsigned FuncW         = 29;
  localparam int unsigned SpeedW        = 8;
  localparam int unsigned ModeW         = 2;
  localparam int unsigned MaskW         = 3;
  localparam int unsigned PktBytes      = 5;
  localparam int unsigned CountW        = 3;
  localparam int unsigned RepW          = 2;
  localparam int unsigned InDataW       = 64;
  localparam int unsigned OutDataW      = 56;
  localparam int unsigned PendW         = 4;

  localparam logic [PreambleW-1:0] PreambleReset = 6'd16;

  localparam logic [7:0] LongAddrMark = 8'hC0;
  localparam logic [7:0] Fun2Op       = 8'hB0;
  localparam logic [7:0] Fun2aOp      = 8'hA0;
  localparam logic [7:0] Fun3Op       = 8'hDE;
  localparam logic [7:0] Fun4Op       = 8'hDF;
  localparam logic [7:0] Speed128Op   = 8'h3F;
  localparam logic [7:0] EstopByte    = 8'h41;
  localparam logic [ModeW-1:0] Mode128 = 2'd3;

  typedef enum logic [2:0] {
    KIND_DRIVE   = 3'd0,
    KIND_FUN1    = 3'd1,
    KIND_FUN2    = 3'd2,
    KIND_FUN2A   = 3'd3,
    KIND_FUN3    = 3'd4,
    KIND_FUN4    = 3'd5,
    KIND_REFRESH = 3'd6,
    KIND_ESTOP   = 3'd7
  } req_kind_e;

  typedef struct packed {
    logic [PktBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic [RepW-1:0]          rep;
  } pkt_t;

  // Assemble one packet: address, instruction bytes, XOR checksum.
  function automatic pkt_t build_pkt(req_kind_e kind, logic [AddrW-1:0] addr,
                                     logic [FuncW-1:0] fbits,
                                     logic [SpeedW-1:0] speed,
                                     logic [ModeW-1:0] mode);
    pkt_t       pkt;
    logic [7:0] i0;
    logic [7:0] i1;
    logic       two_ins;
    logic       long_addr;
    logic [3:0][7:0] hdr;
    logic [7:0] chk;
    logic [CountW-1:0] hn;
    pkt       = '0;
    i1        = 8'h00;
    two_ins   = 1'b0;
    pkt.rep   = 2'd1;
    case (kind)
      KIND_FUN1:  i0 = {3'b100, fbits[0], fbits[4:1]};
      KIND_FUN2:  i0 = Fun2Op | {4'h0, fbits[8:5]};
      KIND_FUN2A: i0 = Fun2aOp | {4'h0, fbits[12:9]};
      KIND_FUN3: begin
        i0 = Fun3Op;
        i1 = fbits[20:13];
        two_ins = 1'b1;
        pkt.rep = 2'd3;
      end
      KIND_FUN4: begin
        i0 = Fun4Op;
        i1 = fbits[28:21];
        two_ins = 1'b1;
        pkt.rep = 2'd3;
      end
      default: begin
        if (mode == Mode128) begin
          i0 = Speed128Op;
          i1 = speed;
          two_ins = 1'b1;
        end else begin
          i0 = {2'b01, speed[7], speed[4:0]};
        end
      end
    endcase
    long_addr = (addr[7:0] != 8'h00);
    if (long_addr) begin
      hdr = {i1, i0, addr[15:8], addr[7:0] | LongAddrMark};
    end else begin
      hdr = {8'h00, i1, i0, addr[15:8]};
    end
    if (kind == KIND_ESTOP) begin
      hdr     = {8'h00, 8'h00, EstopByte, 8'h00};
      two_ins = 1'b0;
      long_addr = 1'b0;
    end
    chk = hdr[0] ^ hdr[1] ^ hdr[2] ^ hdr[3];
    hn  = 3'd2 + {2'b00, long_addr} + {2'b00, two_ins};
    pkt.bytes = {8'h00, hdr};
    pkt.bytes[hn] = chk;
    pkt.count = hn + 3'd1;
    return pkt;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dcc_operation_packet_builder.sv
// ----------------------------------------------------------------------------
// dcc_operation_packet_builder
// Usage: a request word enters on the s_axis channel (kind in tuser, the
// address, function states, speed, speed mode and refresh mask in tdata).
// Each request yields one packet word on m_axis, or for a refresh the drive
// packet and then one packet per function group enabled in the mask, with
// tlast on the final packet of the request.
// A taken request goes to the request register, then its first packet to the
// output register. Throughput: one packet per cycle while m_axis_tready is
// high; single-packet requests are then taken every cycle, a refresh holds the
// request register for each of its packets; one assembler serves all groups.
// When m_axis_tready is low the output register holds its word; the request
// register still fills; s_axis_tready drops when both are full or mid-refresh.
// cfg_we_i writes the preamble length, copied into every following packet;
// write it only while the block is idle.
// Reset (rst_ni low) empties both registers and sets the preamble to 16.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dcc_operation_packet_builder
  import dcc_opb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [PreambleW-1:0] cfg_wdata_i,    // preamble_bits
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // address_word[15:0] function_bits[44:16] speed_byte[52:45]
  // speed_mode[54:53] refresh_mask[57:55], zero pad above
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  input  wire logic [2:0]           s_axis_tuser,   // req_type[2:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // pkt_byte0[7:0] pkt_byte1[15:8] pkt_byte2[23:16] pkt_byte3[31:24]
  // pkt_byte4[39:32] byte_count[42:40] repeat_count[44:43]
  // preamble_len[50:45], zero pad above
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic                      m_axis_tlast    // last_of_run
);

  logic [PreambleW-1:0] preamble_q;

  // request register
  logic              hold_q;
  logic [PendW-1:0]  pend_q, pend_d;
  req_kind_e         kind_q;
  logic [AddrW-1:0]  addr_q;
  logic [FuncW-1:0]  fbits_q;
  logic [SpeedW-1:0] speed_q;
  logic [ModeW-1:0]  mode_q;

  // result register
  logic                 out_valid_q;
  pkt_t                 out_pkt_q;
  logic [PreambleW-1:0] out_pre_q;
  logic                 out_last_q;

  logic             advance, consume, done, accept;
  logic [PendW-1:0] pend_low, pend_rest, pend_new;
  req_kind_e        cur_kind, in_kind;
  pkt_t             cur_pkt;

  assign in_kind = req_kind_e'(s_axis_tuser);

  assign pend_low  = pend_q & (~pend_q + 4'd1);
  assign pend_rest = pend_q & ~pend_low;

  always_comb begin
    cur_kind = kind_q;
    if (kind_q == KIND_REFRESH) begin
      if (pend_q[0]) begin
        cur_kind = KIND_DRIVE;
      end else if (pend_q[1]) begin
        cur_kind = KIND_FUN1;
      end else if (pend_q[2]) begin
        cur_kind = KIND_FUN2;
      end else begin
        cur_kind = KIND_FUN2A;
      end
    end
  end

  assign cur_pkt = build_pkt(cur_kind, addr_q, fbits_q, speed_q, mode_q);

  assign advance = !out_valid_q || m_axis_tready;
  assign consume = hold_q && advance;
  assign done    = consume && (pend_rest == '0);

  assign s_axis_tready = !hold_q || done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // refresh walks drive, then groups 1, 2, 2a as the mask enables them
  assign pend_new = (in_kind == KIND_REFRESH) ? {s_axis_tdata[57:55], 1'b1}
                                              : 4'b0001;

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = pend_new;
    end else if (consume) begin
      pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q  <= PreambleReset;
      hold_q      <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        preamble_q <= cfg_wdata_i;
      end
      if (accept) begin
        hold_q <= 1'b1;
      end else if (done) begin
        hold_q <= 1'b0;
      end
      pend_q <= pend_d;
      if (advance) begin
        out_valid_q <= hold_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_kind;
      addr_q  <= s_axis_tdata[15:0];
      fbits_q <= s_axis_tdata[44:16];
      speed_q <= s_axis_tdata[52:45];
      mode_q  <= s_axis_tdata[54:53];
    end
    if (consume) begin
      out_pkt_q  <= cur_pkt;
      out_pre_q  <= preamble_q;
      out_last_q <= (pend_rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'b00000, out_pre_q, out_pkt_q.rep, out_pkt_q.count,
                          out_pkt_q.bytes};

  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!hold_q && !m_axis_tvalid))
  `ASSERT_CLK(a_hold_has_work, hold_q |-> (pend_q != '0))
  `ASSERT_CLK(a_ready_when_busy, (hold_q && s_axis_tready) |-> (advance && $onehot(pend_q)))
  `ASSERT_CLK(a_single_one_packet, (accept && in_kind != KIND_REFRESH) |=> $onehot(pend_q))
  `ASSERT_CLK(a_count_range, out_valid_q |-> (out_pkt_q.count >= 3'd3 && out_pkt_q.count <= 3'd5))

endmodule

`default_nettype wire

>>> tb/sv/tb_dcc_operation_packet_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dcc_operation_packet_builder
// Drives locomotive requests into the DCC packet builder and checks every
// packet word against an in-bench packet predictor, across several preamble
// settings, with random idles on both streams and long output back-pressure.
// ----------------------------------------------------------------------------

module tb_dcc_operation_packet_builder;
  import dcc_opb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS  = 38;

  localparam logic [7:0] ADDR_LONG_MARK = 8'hC0;
  localparam logic [7:0] OP_FUN1        = 8'h80;
  localparam logic [7:0] OP_FUN2        = 8'hB0;
  localparam logic [7:0] OP_FUN2A       = 8'hA0;
  localparam logic [7:0] OP_FUN3        = 8'hDE;
  localparam logic [7:0] OP_FUN4       = 8'hDF;
  localparam logic [7:0] OP_SPEED128    = 8'h3F;
  localparam logic [7:0] OP_FWD         = 8'h60;
  localparam logic [7:0] OP_REV         = 8'h40;
  localparam logic [7:0] OP_ESTOP       = 8'h41;
  localparam logic [1:0] STEPS_128      = 2'd3;

  typedef struct packed {
    logic [39:0] bytes;     // byte0 in the low bits
    logic [2:0]  count;
    logic [1:0]  rep;
    logic [5:0]  preamble;
    logic        last;
  } dcc_pkt_t;

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] addr;
    logic [28:0] fbits;
    logic [7:0]  speed;
    logic [1:0]  mode;
    logic [2:0]  mask;
    logic        typed;
    dcc_pkt_t    want;
  } dcc_req_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [PreambleW-1:0] cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [2:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  dcc_pkt_t    pending_pkts[$];
  dcc_req_t    req_rows[$];
  logic [5:0]  preamble_cur;
  logic        typed_valid;
  dcc_pkt_t    typed_want;
  bit          no_idle;
  int unsigned hold_reqs;
  int unsigned hold_done;
  int unsigned mismatches;
  int unsigned cycles;

  dcc_operation_packet_builder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // One packet: address bytes, instruction bytes, XOR checksum.
  function automatic dcc_pkt_t frame_packet(input req_kind_e kind, input logic [15:0] addr,
                                            input logic [28:0] fbits, input logic [7:0] speed,
                                            input logic [1:0] mode, input logic [5:0] pre,
                                            input logic last);
    dcc_pkt_t   p;
    logic [7:0] b [0:4];
    logic [7:0] chk;
    int         n;
    int         i;
    for (i = 0; i < 5; i++) b[i] = 8'h00;
    n = 0;
    p.rep = 2'd1;
    if (addr[7:0] == 8'h00) begin
      b[n] = addr[15:8];
      n = n + 1;
    end else begin
      b[n] = addr[7:0] | ADDR_LONG_MARK;
      b[n + 1] = addr[15:8];
      n = n + 2;
    end
    case (kind)
      KIND_FUN1: begin
        b[n] = OP_FUN1 | {3'b000, fbits[0], fbits[4:1]};
        n = n + 1;
      end
      KIND_FUN2: begin
        b[n] = OP_FUN2 | {4'h0, fbits[8:5]};
        n = n + 1;
      end
      KIND_FUN2A: begin
        b[n] = OP_FUN2A | {4'h0, fbits[12:9]};
        n = n + 1;
      end
      KIND_FUN3: begin
        b[n] = OP_FUN3;
        b[n + 1] = fbits[20:13];
        n = n + 2;
        p.rep = 2'd3;
      end
      KIND_FUN4: begin
        b[n] = OP_FUN4;
        b[n + 1] = fbits[28:21];
        n = n + 2;
        p.rep = 2'd3;
      end
      default: begin
        if (mode == STEPS_128) begin
          b[n] = OP_SPEED128;
          b[n + 1] = speed;
          n = n + 2;
        end else begin
          b[n] = (speed[7] ? OP_FWD : OP_REV) | {3'b000, speed[4:0]};
          n = n + 1;
        end
      end
    endcase
    chk = 8'h00;
    for (i = 0; i < n; i++) chk = chk ^ b[i];
    b[n] = chk;
    n = n + 1;
    p.bytes    = {b[4], b[3], b[2], b[1], b[0]};
    p.count    = n[2:0];
    p.preamble = pre;
    p.last     = last;
    return p;
  endfunction

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted request, check every accepted packet word.
  always @(posedge clk_i) begin : scoreboard
    req_kind_e   kind;
    logic [15:0] addr;
    logic [28:0] fbits;
    logic [7:0]  speed;
    logic [1:0]  mode;
    logic [2:0]  mask;
    dcc_pkt_t    want;
    int          g;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        kind  = req_kind_e'(s_axis_tuser);
        addr  = s_axis_tdata[15:0];
        fbits = s_axis_tdata[44:16];
        speed = s_axis_tdata[52:45];
        mode  = s_axis_tdata[54:53];
        mask  = s_axis_tdata[57:55];
        if (typed_valid) begin
          pending_pkts.push_back(typed_want);
        end else if (kind == KIND_ESTOP) begin
          want.bytes    = {8'h00, 8'h00, OP_ESTOP, OP_ESTOP, 8'h00};
          want.count    = 3'd3;
          want.rep      = 2'd1;
          want.preamble = preamble_cur;
          want.last     = 1'b1;
          pending_pkts.push_back(want);
        end else if (kind == KIND_REFRESH) begin
          pending_pkts.push_back(frame_packet(KIND_DRIVE, addr, fbits, speed, mode,
                                              preamble_cur, mask == 3'd0));
          for (g = 0; g < 3; g++) begin
            if (mask[g]) begin
              pending_pkts.push_back(frame_packet(req_kind_e'(g + 1), addr, fbits, speed,
                                                  mode, preamble_cur, (mask >> (g + 1)) == 0));
            end
          end
        end else begin
          pending_pkts.push_back(frame_packet(kind, addr, fbits, speed, mode,
                                              preamble_cur, 1'b1));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pkts.size() == 0) begin
          $display("%0t unexpected packet word, expected none actual %h last %b", $time,
                   m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = pending_pkts.pop_front();
          for (g = 0; g < 5; g++) begin
            report($sformatf("pkt_byte%0d", g), want.bytes[8*g +: 8], m_axis_tdata[8*g +: 8]);
          end
          report("byte_count", {5'd0, want.count}, {5'd0, m_axis_tdata[42:40]});
          report("repeat_count", {6'd0, want.rep}, {6'd0, m_axis_tdata[44:43]});
          report("preamble_len", {2'd0, want.preamble}, {2'd0, m_axis_tdata[50:45]});
          report("last_of_run", {7'd0, want.last}, {7'd0, m_axis_tlast});
        end
      end
      if (cfg_we_i) preamble_cur = cfg_wdata_i;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, pending_pkts.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random wait per word, plus long holds on request.
  initial begin : receiver
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_reqs) begin
        hold_done++;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic add_row(input req_kind_e kind, input logic [15:0] addr,
                         input logic [28:0] fbits, input logic [7:0] speed,
                         input logic [1:0] mode, input logic [2:0] mask,
                         input logic typed, input dcc_pkt_t want);
    dcc_req_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.fbits = fbits;
    r.speed = speed;
    r.mode  = mode;
    r.mask  = mask;
    r.typed = typed;
    r.want  = want;
    req_rows.push_back(r);
  endtask

  task automatic offer(input dcc_req_t r);
    int gap;
    gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {6'b000000, r.mask, r.mode, r.speed, r.fbits, r.addr};
    s_axis_tuser  = r.kind;
    typed_valid   = r.typed;
    typed_want    = r.want;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every outstanding packet word.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    typed_valid   = 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    dcc_req_t   r;
    dcc_pkt_t   none;
    logic [5:0] settings [0:4];
    int         ph;
    int         k;
    cycles        = 0;
    mismatches    = 0;
    hold_reqs     = 0;
    hold_done     = 0;
    no_idle       = 1'b0;
    preamble_cur  = 6'd16;
    typed_valid   = 1'b0;
    typed_want    = '0;
    none          = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;

    // Typed rows rely on the reset preamble of 16.
    add_row(KIND_ESTOP, 16'hFFFF, 29'h1FFFFFFF, 8'hFF, 2'd3, 3'd7, 1'b1,
            '{40'h00_00_41_41_00, 3'd3, 2'd1, 6'd16, 1'b1});
    add_row(KIND_DRIVE, 16'h0000, 29'h0, 8'h00, 2'd0, 3'd0, 1'b1,
            '{40'h00_00_40_40_00, 3'd3, 2'd1, 6'd16, 1'b1});
    add_row(KIND_FUN4, 16'hFFFF, 29'h1FFFFFFF, 8'hFF, 2'd3, 3'd7, 1'b1,
            '{40'h20_FF_DF_FF_FF, 3'd5, 2'd3, 6'd16, 1'b1});
    add_row(KIND_DRIVE, 16'hFF00, 29'h0, 8'hFF, 2'd3, 3'd0, 1'b1,
            '{40'h00_3F_FF_3F_FF, 3'd4, 2'd1, 6'd16, 1'b1});
    add_row(KIND_DRIVE, 16'h00FF, 29'h0, 8'h80, 2'd1, 3'd0, 1'b0, none);
    add_row(KIND_DRIVE, 16'h1234, 29'h0, 8'h7F, 2'd2, 3'd0, 1'b0, none);
    add_row(KIND_DRIVE, 16'h0300, 29'h1FFFFFFF, 8'hE5, 2'd0, 3'd7, 1'b0, none);
    add_row(KIND_FUN1, 16'h0500, 29'h0000001F, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN1, 16'h0501, 29'h00000001, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN1, 16'h0700, 29'h1FFFFFE0, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN2, 16'h0A00, 29'h000001E0, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN2, 16'h2A80, 29'h1FFFFE1F, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN2A, 16'h0B00, 29'h00001E00, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN3, 16'h0C00, 29'h001FE000, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN3, 16'hC3C3, 29'h1FE01FFF, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_FUN4, 16'h6400, 29'h1FE00000, 8'h00, 2'd0, 3'd0, 1'b0, none);
    add_row(KIND_REFRESH, 16'h0400, 29'h00001FFF, 8'h9A, 2'd1, 3'd0, 1'b0, none);
    add_row(KIND_REFRESH, 16'hABCD, 29'h15555555, 8'hC3, 2'd3, 3'd7, 1'b0, none);
    add_row(KIND_REFRESH, 16'h0800, 29'h0AAAAAAA, 8'h11, 2'd2, 3'd1, 1'b0, none);
    add_row(KIND_REFRESH, 16'h0801, 29'h0AAAAAAA, 8'h91, 2'd0, 3'd2, 1'b0, none);
    add_row(KIND_REFRESH, 16'h0900, 29'h1FFFFFFF, 8'hFF, 2'd3, 3'd4, 1'b0, none);
    add_row(KIND_REFRESH, 16'h0902, 29'h00000000, 8'h00, 2'd0, 3'd5, 1'b0, none);
    add_row(KIND_ESTOP, 16'h0000, 29'h0, 8'h00, 2'd0, 3'd0, 1'b0, none);

    settings[0] = 6'd10;
    settings[1] = 6'd63;
    settings[2] = 6'd0;
    settings[3] = 6'd9;
    settings[4] = $urandom_range(11, 62);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (req_rows[i]) offer(req_rows[i]);

    for (ph = 0; ph < 5; ph++) begin
      drain();
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_wdata_i = settings[ph];
      @(negedge clk_i);
      cfg_we_i    = 1'b0;
      no_idle     = (ph == 1 || ph == 3);
      // Stall the output while the sender keeps going, so the block backs up.
      if (ph == 1 || ph == 3) hold_reqs++;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r.kind  = req_kind_e'($urandom_range(0, 7));
        r.addr  = $urandom_range(0, 2) == 0 ? {8'($urandom), 8'h00} : 16'($urandom);
        r.fbits = 29'($urandom);
        r.speed = 8'($urandom);
        r.mode  = 2'($urandom_range(0, 3));
        r.mask  = 3'($urandom_range(0, 7));
        r.typed = 1'b0;
        r.want  = none;
        offer(r);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
